### rtl/core/cclog_pkg.sv
`default_nettype none

package cclog_pkg;

  localparam int unsigned SLOTS_PER_SECTOR_DEF = 4096;

  localparam logic [31:0] LOG_MAGIC = 32'h564B_484F;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

  localparam int unsigned MSG_BITS = 224;
  localparam int unsigned SEQ_LSB  = 64;

  localparam logic [19:0] RESERVE_RST = 20'd4096;

  localparam logic [2:0] CFG_RESERVE     = 3'd0;
  localparam logic [2:0] CFG_BOOT_CEIL   = 3'd1;
  localparam logic [2:0] CFG_BOOT_SEQ    = 3'd2;
  localparam logic [2:0] CFG_BOOT_SLOT   = 3'd3;
  localparam logic [2:0] CFG_BOOT_SECTOR = 3'd4;
  localparam logic [2:0] CFG_BOOT_SPARE  = 3'd5;
  localparam logic [2:0] CFG_READY       = 3'd6;

  localparam logic [2:0] ST_INSIDE  = 3'd0;
  localparam logic [2:0] ST_WRITTEN = 3'd1;
  localparam logic [2:0] ST_REFUSED = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_FAILED  = 3'd4;

  typedef struct packed {
    logic [19:0] reserve;
    logic [31:0] boot_ceiling;
    logic [31:0] boot_sequence;
    logic [12:0] boot_slot;
    logic        boot_sector;
    logic        boot_spare_clean;
    logic        store_ready;
    logic        reload;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        counter_safe;
    logic        write_request;
    logic        write_sector;
    logic [11:0] write_slot;
    logic [31:0] record_sequence;
    logic [31:0] record_ceiling;
    logic [31:0] record_check;
    logic [13:0] slots_left;
    logic [31:0] writes_done;
    logic [31:0] errors_seen;
    logic        exhausted;
  } result_t;

  typedef logic [63:0][31:0] crc_cols_t;

  // bitwise reflected crc, message bit 0 of byte 0 first
  function automatic logic [31:0] crc_bits(input logic [MSG_BITS-1:0] msg,
                                           input logic [31:0] init);
    logic [31:0] c;
    logic        fb;
    c = init;
    for (int j = 0; j < MSG_BITS; j++) begin
      fb = c[0] ^ msg[j];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // linear contribution of each sequence and ceiling bit
  function automatic crc_cols_t crc_cols_f();
    crc_cols_t              cols;
    logic [MSG_BITS-1:0]    msg;
    for (int i = 0; i < 64; i++) begin
      msg = '0;
      msg[SEQ_LSB + i] = 1'b1;
      cols[i] = crc_bits(msg, '0);
    end
    return cols;
  endfunction

  localparam logic [MSG_BITS-1:0] BASE_MSG =
    MSG_BITS'(LOG_MAGIC) | (MSG_BITS'(1) << 32) | (MSG_BITS'(1) << 40);

  localparam logic [31:0] CRC_BASE  = crc_bits(BASE_MSG, ALL_ONES) ^ ALL_ONES;
  localparam crc_cols_t   CRC_COLS  = crc_cols_f();

endpackage

`default_nettype wire

### rtl/core/cclog_cfg.sv
`default_nettype none

module cclog_cfg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output cclog_pkg::cfg_t         cfg
);

  logic [19:0] reserve_r;
  logic [31:0] boot_ceil_r;
  logic [31:0] boot_seq_r;
  logic [12:0] boot_slot_r;
  logic        boot_sector_r;
  logic        boot_spare_r;
  logic        ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserve_r     <= cclog_pkg::RESERVE_RST;
      boot_ceil_r   <= '0;
      boot_seq_r    <= '0;
      boot_slot_r   <= '0;
      boot_sector_r <= 1'b0;
      boot_spare_r  <= 1'b0;
      ready_r       <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cclog_pkg::CFG_RESERVE:     reserve_r     <= cfg_data[19:0];
        cclog_pkg::CFG_BOOT_CEIL:   boot_ceil_r   <= cfg_data;
        cclog_pkg::CFG_BOOT_SEQ:    boot_seq_r    <= cfg_data;
        cclog_pkg::CFG_BOOT_SLOT:   boot_slot_r   <= cfg_data[12:0];
        cclog_pkg::CFG_BOOT_SECTOR: boot_sector_r <= cfg_data[0];
        cclog_pkg::CFG_BOOT_SPARE:  boot_spare_r  <= cfg_data[0];
        cclog_pkg::CFG_READY:       ready_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.reserve          = reserve_r;
    cfg.boot_ceiling     = boot_ceil_r;
    cfg.boot_sequence    = boot_seq_r;
    cfg.boot_slot        = boot_slot_r;
    cfg.boot_sector      = boot_sector_r;
    cfg.boot_spare_clean = boot_spare_r;
    cfg.store_ready      = ready_r;
    cfg.reload           = cfg_wr_en && (cfg_index == cclog_pkg::CFG_READY);
  end

endmodule

`default_nettype wire

### rtl/core/cclog_crc.sv
`default_nettype none

module cclog_crc (
  input  wire logic [31:0] rec_sequence,
  input  wire logic [31:0] rec_ceiling,
  output logic      [31:0] rec_check
);

  logic [63:0] data;

  assign data = {rec_ceiling, rec_sequence};

  always_comb begin
    rec_check = cclog_pkg::CRC_BASE;
    for (int i = 0; i < 64; i++) begin
      if (data[i]) begin
        rec_check = rec_check ^ cclog_pkg::CRC_COLS[i];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/cclog_state.sv
`default_nettype none

module cclog_state #(
  parameter int unsigned SLOTS_PER_SECTOR = cclog_pkg::SLOTS_PER_SECTOR_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cclog_pkg::cfg_t    cfg,
  input  wire logic               step_en,
  input  wire logic [31:0]        counter_value,
  input  wire logic               flash_refuses,
  output cclog_pkg::result_t      res
);

  localparam logic [12:0] SLOTS_N = 13'(SLOTS_PER_SECTOR);

  logic [31:0] ceil_r,  ceil_nxt;
  logic [31:0] seq_r,   seq_nxt;
  logic [12:0] slot_r,  slot_nxt;
  logic        sec_r,   sec_nxt;
  logic        spare_r, spare_nxt;
  logic        exh_r,   exh_nxt;
  logic [31:0] wtot_r,  wtot_nxt;
  logic [31:0] etot_r,  etot_nxt;

  logic [31:0] diff;
  logic        below;
  logic        full;
  logic [31:0] rec_seq;
  logic [31:0] rec_ceil;
  logic [31:0] rec_chk;
  logic [12:0] left;

  assign diff     = counter_value - ceil_r;
  assign below    = diff[31];
  assign full     = slot_r >= SLOTS_N;
  assign rec_seq  = seq_r + 32'd1;
  assign rec_ceil = counter_value + {12'd0, cfg.reserve};

  cclog_crc u_crc (
    .rec_sequence (rec_seq),
    .rec_ceiling  (rec_ceil),
    .rec_check    (rec_chk)
  );

  always_comb begin
    ceil_nxt  = ceil_r;
    seq_nxt   = seq_r;
    slot_nxt  = slot_r;
    sec_nxt   = sec_r;
    spare_nxt = spare_r;
    exh_nxt   = exh_r;
    wtot_nxt  = wtot_r;
    etot_nxt  = etot_r;
    res       = '0;
    res.counter_safe = cfg.store_ready && below;

    if (!cfg.store_ready || exh_r) begin
      res.status = cclog_pkg::ST_REFUSED;
    end else if (below) begin
      res.status = cclog_pkg::ST_INSIDE;
    end else if (full && !spare_r) begin
      etot_nxt   = etot_r + 32'd1;
      exh_nxt    = 1'b1;
      res.status = cclog_pkg::ST_FULL;
    end else begin
      // swap to the spare sector
      if (full) begin
        sec_nxt   = ~sec_r;
        slot_nxt  = '0;
        spare_nxt = 1'b0;
      end
      res.write_request   = 1'b1;
      res.write_sector    = sec_nxt;
      res.write_slot      = slot_nxt[11:0];
      res.record_sequence = rec_seq;
      res.record_ceiling  = rec_ceil;
      res.record_check    = rec_chk;
      if (flash_refuses) begin
        etot_nxt   = etot_r + 32'd1;
        exh_nxt    = 1'b1;
        res.status = cclog_pkg::ST_FAILED;
      end else begin
        seq_nxt    = rec_seq;
        slot_nxt   = slot_nxt + 13'd1;
        wtot_nxt   = wtot_r + 32'd1;
        ceil_nxt   = rec_ceil;
        res.status = cclog_pkg::ST_WRITTEN;
      end
    end

    left = (slot_nxt < SLOTS_N) ? (SLOTS_N - slot_nxt) : 13'd0;
    res.slots_left  = {1'b0, left} + (spare_nxt ? {1'b0, SLOTS_N} : 14'd0);
    res.writes_done = wtot_nxt;
    res.errors_seen = etot_nxt;
    res.exhausted   = exh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r  <= '0;
      seq_r   <= '0;
      slot_r  <= '0;
      sec_r   <= 1'b0;
      spare_r <= 1'b0;
      exh_r   <= 1'b0;
      wtot_r  <= '0;
      etot_r  <= '0;
    end else if (cfg.reload) begin
      ceil_r  <= cfg.boot_ceiling;
      seq_r   <= cfg.boot_sequence;
      slot_r  <= cfg.boot_slot;
      sec_r   <= cfg.boot_sector;
      spare_r <= cfg.boot_spare_clean;
      exh_r   <= 1'b0;
    end else if (step_en) begin
      ceil_r  <= ceil_nxt;
      seq_r   <= seq_nxt;
      slot_r  <= slot_nxt;
      sec_r   <= sec_nxt;
      spare_r <= spare_nxt;
      exh_r   <= exh_nxt;
      wtot_r  <= wtot_nxt;
      etot_r  <= etot_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/counter_ceiling_flash_log.sv
// Counter ceiling store with a two-sector flash log. One word is taken per
// clock while the output is not stalled, and each word gives exactly one
// result word: the word is captured in an input register, then the ceiling
// compare, the new record (sequence, ceiling, crc-32) and the state update
// are worked out in a single pass into the output register, so the sustained
// rate is one word per cycle, set by the read-modify-write of the log state.
// Boot scan results are loaded through the configuration port; writing the
// store_ready register reloads the log state from the boot registers and
// clears the exhaustion latch, while the write and error totals are kept.
// Until store_ready is written with 1 every word is refused.
`default_nettype none

module counter_ceiling_flash_log #(
  parameter int unsigned SLOTS_PER_SECTOR = cclog_pkg::SLOTS_PER_SECTOR_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_counter_value,
  input  wire logic        in_flash_refuses,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_counter_safe,
  output logic             out_write_request,
  output logic             out_write_sector,
  output logic [11:0]      out_write_slot,
  output logic [31:0]      out_record_sequence,
  output logic [31:0]      out_record_ceiling,
  output logic [31:0]      out_record_check,
  output logic [13:0]      out_slots_left,
  output logic [31:0]      out_writes_done,
  output logic [31:0]      out_errors_seen,
  output logic             out_exhausted
);

  cclog_pkg::cfg_t    cfg;
  cclog_pkg::result_t res;
  cclog_pkg::result_t out_r;

  logic        in_v_r;
  logic [31:0] in_cnt_r;
  logic        in_ref_r;
  logic        out_v_r;
  logic        out_load;
  logic        fire;

  assign out_load = !out_v_r || !out_stall;
  assign fire     = in_v_r && out_load;
  assign in_stall = in_v_r && !out_load;

  cclog_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cclog_state #(
    .SLOTS_PER_SECTOR (SLOTS_PER_SECTOR)
  ) u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .step_en       (fire),
    .counter_value (in_cnt_r),
    .flash_refuses (in_ref_r),
    .res           (res)
  );

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cnt_r <= in_counter_value;
      in_ref_r <= in_flash_refuses;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_v_r;
  assign out_status          = out_r.status;
  assign out_counter_safe    = out_r.counter_safe;
  assign out_write_request   = out_r.write_request;
  assign out_write_sector    = out_r.write_sector;
  assign out_write_slot      = out_r.write_slot;
  assign out_record_sequence = out_r.record_sequence;
  assign out_record_ceiling  = out_r.record_ceiling;
  assign out_record_check    = out_r.record_check;
  assign out_slots_left      = out_r.slots_left;
  assign out_writes_done     = out_r.writes_done;
  assign out_errors_seen     = out_r.errors_seen;
  assign out_exhausted       = out_r.exhausted;

  a_req_status : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_request |->
      out_status == cclog_pkg::ST_WRITTEN || out_status == cclog_pkg::ST_FAILED)
    else $error("write request with a status that attempts no write");

  a_fail_latch : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == cclog_pkg::ST_FULL ||
                  out_status == cclog_pkg::ST_FAILED) |-> out_exhausted)
    else $error("error status without the exhaustion latch");

  a_fire_out : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("word left the input register but no result appeared");

endmodule

`default_nettype wire
